// ===== hw/rtl/rgb_conv3x3_clamp_assert.svh =====
// Assertion macros for the 3x3 convolution filter.
`ifndef RGB_CONV3X3_CLAMP_ASSERT_SVH
`define RGB_CONV3X3_CLAMP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RGBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define RGBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rgbc_pkg.sv =====
// Types and constants shared by the 3x3 convolution filter.
package rgbc_pkg;

	localparam int NUM_TAPS   = 9;
	localparam int COEF_W     = 7;
	localparam int CHAN_W     = 8;
	localparam int RGB_W      = 24;
	localparam int CFG_W      = 63;
	localparam int IMG_W      = 12;
	localparam int ROW_W      = 12;
	localparam int OCOL_W     = 11;
	localparam int PROD_W     = 16;
	localparam int SUM_W      = 19;
	localparam int MAG_W      = 18;
	localparam int DIV9_MUL   = 233017;
	localparam int DIV9_SHIFT = 21;
	localparam int CHAN_MAX   = 255;
	localparam int MIN_DIM    = 3;
	localparam int WIDTH_RST  = 640;
	localparam int HEIGHT_RST = 480;
	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

	typedef enum logic [1:0] {
		CFG_KERNEL_COEFS   = 2'd0,
		CFG_DIVIDE_BY_NINE = 2'd1,
		CFG_IMAGE_WIDTH    = 2'd2,
		CFG_IMAGE_HEIGHT   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] pixel_argb;
		logic        start_of_frame;
	} pix_req_t;

	typedef struct packed {
		logic [31:0]       out_argb;
		logic [ROW_W-1:0]  out_row;
		logic [OCOL_W-1:0] out_col;
		logic              last_of_frame;
	} res_t;

	typedef struct packed {
		logic ld_prod;
		logic ld_sum;
		logic ld_div;
		logic ld_out;
	} filt_en_t;

endpackage

// ===== hw/rtl/rgbc_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
interface rgbc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rgbc_ram.sv =====
// Generic simple dual-port RAM with registered read.
module rgbc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/rgbc_chan_filter.sv =====
// One color channel: weighted 3x3 sum, optional divide by nine, clamp.
module rgbc_chan_filter (
	input  logic                                              clk,
	input  rgbc_pkg::filt_en_t                                en,
	input  logic                                              divide_by_nine,
	input  logic [rgbc_pkg::CFG_W-1:0]                        kernel_coefs,
	input  logic [rgbc_pkg::NUM_TAPS-1:0][rgbc_pkg::CHAN_W-1:0] pix,
	output logic [rgbc_pkg::CHAN_W-1:0]                       chan_q
);
	import rgbc_pkg::*;

	logic signed [PROD_W-1:0] prod_d  [NUM_TAPS];
	logic signed [PROD_W-1:0] prod_s3 [NUM_TAPS];
	logic signed [SUM_W-1:0]  sum_d;
	logic signed [SUM_W-1:0]  sum_s4;
	logic signed [SUM_W-1:0]  s01, s23, s45, s67;
	logic [MAG_W-1:0]         mag_d;
	logic [2*MAG_W-1:0]       div_prod;
	logic [MAG_W-1:0]         val_d;
	logic [MAG_W-1:0]         val_s5;
	logic                     neg_s5;

	always_comb begin
		for (int k = 0; k < NUM_TAPS; k++) begin
			prod_d[k] = $signed({1'b0, pix[k]}) * $signed(kernel_coefs[COEF_W*k +: COEF_W]);
		end
	end

	always_comb begin
		s01   = SUM_W'(prod_s3[0]) + SUM_W'(prod_s3[1]);
		s23   = SUM_W'(prod_s3[2]) + SUM_W'(prod_s3[3]);
		s45   = SUM_W'(prod_s3[4]) + SUM_W'(prod_s3[5]);
		s67   = SUM_W'(prod_s3[6]) + SUM_W'(prod_s3[7]);
		sum_d = (s01 + s23) + (s45 + s67) + SUM_W'(prod_s3[8]);
	end

	always_comb begin
		mag_d    = sum_s4[MAG_W-1:0];
		div_prod = (2*MAG_W)'(mag_d) * (2*MAG_W)'(DIV9_MUL);
		val_d    = divide_by_nine ? MAG_W'(div_prod >> DIV9_SHIFT) : mag_d;
	end

	always_ff @(posedge clk) begin
		if (en.ld_prod) begin
			prod_s3 <= prod_d;
		end
		if (en.ld_sum) begin
			sum_s4 <= sum_d;
		end
		if (en.ld_div) begin
			neg_s5 <= sum_s4[SUM_W-1];
			val_s5 <= val_d;
		end
		if (en.ld_out) begin
			if (neg_s5) begin
				chan_q <= '0;
			end else if (val_s5 > MAG_W'(CHAN_MAX)) begin
				chan_q <= CHAN_W'(CHAN_MAX);
			end else begin
				chan_q <= val_s5[CHAN_W-1:0];
			end
		end
	end
endmodule

// ===== hw/rtl/rgb_conv3x3_clamp.sv =====
// Top level of the 3x3 convolution filter with clamped RGB output.
// Pixels enter in raster order, one per clock when the output side keeps up;
// each interior pixel yields one result through the line-buffer, window,
// product, sum, divide and output registers, border pixels yield none.
// The two previous lines sit in one RAM of MAX_WIDTH entries, read and
// written once per pixel, so a line may be at most MAX_WIDTH pixels wide.
// Six pipeline stages each hold one pixel and drain independently, so a
// finished result waiting at the output does not stop new pixels until every
// stage is full. Write the configuration only while no pixel is in flight.
module rgb_conv3x3_clamp #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [rgbc_pkg::CFG_W-1:0]    cfg_wdata,
	rgbc_stream_if.sink                   pix_in,
	rgbc_stream_if.source                 res_out
);
	import rgbc_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int EWN = $clog2(MAX_WIDTH + 1);
	localparam int EW  = (EWN > IMG_W) ? EWN : IMG_W;

	typedef struct packed {
		logic [ROW_W-1:0]  orow;
		logic [OCOL_W-1:0] ocol;
		logic              emit;
		logic              last;
	} meta_t;

	// configuration
	logic [CFG_W-1:0] kernel_coefs_q;
	logic             divide_by_nine_q;
	logic [IMG_W-1:0] image_width_q;
	logic [IMG_W-1:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_coefs_q   <= '0;
			divide_by_nine_q <= 1'b0;
			image_width_q    <= IMG_W'(WIDTH_RST);
			image_height_q   <= IMG_W'(HEIGHT_RST);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_KERNEL_COEFS:   kernel_coefs_q   <= cfg_wdata;
				CFG_DIVIDE_BY_NINE: divide_by_nine_q <= cfg_wdata[0];
				CFG_IMAGE_WIDTH:    image_width_q    <= cfg_wdata[IMG_W-1:0];
				CFG_IMAGE_HEIGHT:   image_height_q   <= cfg_wdata[IMG_W-1:0];
			endcase
		end
	end

	// effective frame size
	logic [EW-1:0]    img_w_x;
	logic [EW-1:0]    eff_w;
	logic [ROW_W-1:0] eff_h;

	always_comb begin
		img_w_x = EW'(image_width_q);
		if (img_w_x < EW'(MIN_DIM)) begin
			eff_w = EW'(MIN_DIM);
		end else if (img_w_x > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = img_w_x;
		end
		eff_h = (image_height_q < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : image_height_q;
	end

	// handshake chain
	logic  v1, v2, v3, v4, v5, out_v_q;
	logic  take1, take2, take3, take4, take5;
	logic  rdy1, rdy2, rdy3, rdy4, rdy5;
	logic  acc;
	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_q;

	always_comb begin
		take5 = v5 && (!meta_s5.emit || !out_v_q || res_out.ready);
		rdy5  = !v5 || take5;
		take4 = v4 && rdy5;
		rdy4  = !v4 || take4;
		take3 = v3 && rdy4;
		rdy3  = !v3 || take3;
		take2 = v2 && rdy3;
		rdy2  = !v2 || take2;
		take1 = v1 && rdy2;
		rdy1  = !v1 || take1;
	end

	assign pix_in.ready = rdy1;
	assign acc          = pix_in.valid && rdy1;

	// position tracking
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [EW-1:0]    col0, col1, col_inc;
	logic [ROW_W:0]   row0, row1, row2, row_inc;
	logic [ROW_W-1:0] cur_row;
	logic [CW-1:0]    cur_col;
	logic [CW-1:0]    col_nxt;
	logic [ROW_W-1:0] row_nxt;
	meta_t            meta_d;

	always_comb begin
		col0 = pix_in.data.start_of_frame ? '0 : EW'(col_q);
		row0 = pix_in.data.start_of_frame ? '0 : {1'b0, row_q};
		if (col0 >= eff_w) begin
			col1 = '0;
			row1 = row0 + 1'b1;
		end else begin
			col1 = col0;
			row1 = row0;
		end
		row2    = (row1 >= {1'b0, eff_h}) ? '0 : row1;
		cur_row = row2[ROW_W-1:0];
		cur_col = CW'(col1);
		col_inc = col1 + 1'b1;
		row_inc = {1'b0, cur_row} + 1'b1;
		if (col_inc >= eff_w) begin
			col_nxt = '0;
			row_nxt = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[ROW_W-1:0];
		end else begin
			col_nxt = CW'(col_inc);
			row_nxt = cur_row;
		end
		meta_d.orow = cur_row - 1'b1;
		meta_d.ocol = OCOL_W'(col1 - 1'b1);
		meta_d.emit = (cur_row >= ROW_W'(2)) && (col1 >= EW'(2));
		meta_d.last = (cur_row == eff_h - 1'b1) && (col1 == eff_w - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// line buffers: upper half is two lines above, lower half one line above
	logic [2*RGB_W-1:0] ram_rdata;
	logic [2*RGB_W-1:0] line_d;
	logic [2*RGB_W-1:0] wr_data;
	logic [RGB_W-1:0]   px_s1;
	logic [CW-1:0]      wcol_s1;
	logic               fwd_s1;
	logic [2*RGB_W-1:0] fwd_d_s1;
	logic [RGB_W-1:0]   above;
	logic [RGB_W-1:0]   two_above;

	rgbc_ram #(
		.WIDTH (2*RGB_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (take1),
		.waddr (wcol_s1),
		.wdata (wr_data),
		.re    (acc),
		.raddr (cur_col),
		.rdata (ram_rdata)
	);

	always_comb begin
		line_d    = fwd_s1 ? fwd_d_s1 : ram_rdata;
		above     = line_d[RGB_W-1:0];
		two_above = line_d[2*RGB_W-1:RGB_W];
		wr_data   = {above, px_s1};
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1    <= pix_in.data.pixel_argb[RGB_W-1:0];
			wcol_s1  <= cur_col;
			meta_s1  <= meta_d;
			fwd_s1   <= take1 && (wcol_s1 == cur_col);
			fwd_d_s1 <= wr_data;
		end
	end

	// 3x3 window
	logic [RGB_W-1:0] win_q [NUM_TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_TAPS; k++) begin
				win_q[k] <= '0;
			end
		end else if (take1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= two_above;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= above;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= px_s1;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1      <= 1'b0;
			v2      <= 1'b0;
			v3      <= 1'b0;
			v4      <= 1'b0;
			v5      <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				v1 <= 1'b1;
			end else if (take1) begin
				v1 <= 1'b0;
			end
			if (take1) begin
				v2 <= 1'b1;
			end else if (take2) begin
				v2 <= 1'b0;
			end
			if (take2) begin
				v3 <= 1'b1;
			end else if (take3) begin
				v3 <= 1'b0;
			end
			if (take3) begin
				v4 <= 1'b1;
			end else if (take4) begin
				v4 <= 1'b0;
			end
			if (take4) begin
				v5 <= 1'b1;
			end else if (take5) begin
				v5 <= 1'b0;
			end
			if (take5 && meta_s5.emit) begin
				out_v_q <= 1'b1;
			end else if (res_out.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// position metadata
	always_ff @(posedge clk) begin
		if (take1) begin
			meta_s2 <= meta_s1;
		end
		if (take2) begin
			meta_s3 <= meta_s2;
		end
		if (take3) begin
			meta_s4 <= meta_s3;
		end
		if (take4) begin
			meta_s5 <= meta_s4;
		end
		if (take5 && meta_s5.emit) begin
			meta_q <= meta_s5;
		end
	end

	// channel datapaths: blue, green, red
	filt_en_t                             filt_en;
	logic [NUM_TAPS-1:0][CHAN_W-1:0]      chan_pix [3];
	logic [CHAN_W-1:0]                    chan_res [3];

	assign filt_en = '{
		ld_prod: take2,
		ld_sum:  take3,
		ld_div:  take4,
		ld_out:  take5 && meta_s5.emit
	};

	for (genvar c = 0; c < 3; c++) begin : g_chan
		always_comb begin
			for (int k = 0; k < NUM_TAPS; k++) begin
				chan_pix[c][k] = win_q[k][CHAN_W*c +: CHAN_W];
			end
		end

		rgbc_chan_filter u_filt (
			.clk            (clk),
			.en             (filt_en),
			.divide_by_nine (divide_by_nine_q),
			.kernel_coefs   (kernel_coefs_q),
			.pix            (chan_pix[c]),
			.chan_q         (chan_res[c])
		);
	end

	// result
	res_t res_d;

	always_comb begin
		res_d.out_argb      = {ALPHA_OPAQUE, chan_res[2], chan_res[1], chan_res[0]};
		res_d.out_row       = meta_q.orow;
		res_d.out_col       = meta_q.ocol;
		res_d.last_of_frame = meta_q.last;
	end

	assign res_out.valid = out_v_q;
	assign res_out.data  = res_d;

	`include "rgb_conv3x3_clamp_assert.svh"

	`RGBC_ASSERT_NOW(a_res_interior, clk, arst_n, res_out.valid, (res_out.data.out_row != '0) && (res_out.data.out_col != '0), "result for a border pixel")
	`RGBC_ASSERT_NEXT(a_col_in_range, clk, arst_n, acc, EW'(col_q) < eff_w, "column counter beyond line width")
	`RGBC_ASSERT_NOW(a_stall_full, clk, arst_n, !pix_in.ready, v1 && v2 && v3 && v4 && v5 && out_v_q, "request refused with a free stage")
endmodule

// ===== sim/rgb_conv3x3_clamp_test.sv =====
// Self-checking testbench for the 3x3 RGB convolution filter with clamped output.
`timescale 1ns / 1ps

module rgb_conv3x3_clamp_test;
	import rgbc_pkg::*;

	localparam int     MAX_WIDTH    = 2048;
	localparam int     RANDOM_ITEMS = 1280;
	localparam int     DRAIN_CYCLES = 16;
	localparam int     ERR_SHOW     = 40;
	localparam longint LIMIT_NS     = 40_000_000;

	class filtered_pixel_board;
		logic [CFG_W-1:0]  taps_reg;
		bit                blur;
		logic [IMG_W-1:0]  width_reg;
		logic [IMG_W-1:0]  height_reg;
		logic [RGB_W-1:0]  line_above [MAX_WIDTH];
		logic [RGB_W-1:0]  line_two_above [MAX_WIDTH];
		logic [RGB_W-1:0]  window [NUM_TAPS];
		int unsigned       col;
		int unsigned       row;
		res_t              pending_filtered [$];
		int                mismatches;
		int                results_seen;

		function new();
			taps_reg = '0;
			blur = 1'b0;
			width_reg = IMG_W'(WIDTH_RST);
			height_reg = IMG_W'(HEIGHT_RST);
			foreach (line_above[i]) begin
				line_above[i] = '0;
				line_two_above[i] = '0;
			end
			foreach (window[i]) window[i] = '0;
			col = 0;
			row = 0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
			case (idx)
				CFG_KERNEL_COEFS:   taps_reg = value;
				CFG_DIVIDE_BY_NINE: blur = value[0];
				CFG_IMAGE_WIDTH:    width_reg = value[IMG_W-1:0];
				CFG_IMAGE_HEIGHT:   height_reg = value[IMG_W-1:0];
			endcase
		endfunction

		function logic [CHAN_W-1:0] weigh_channel(int lsb);
			int acc;
			logic signed [COEF_W-1:0] tap;
			acc = 0;
			for (int k = 0; k < NUM_TAPS; k++) begin
				tap = taps_reg[COEF_W*k +: COEF_W];
				acc += int'(tap) * int'(window[k][lsb +: CHAN_W]);
			end
			if (blur)
				acc = acc / 9;
			if (acc > CHAN_MAX)
				acc = CHAN_MAX;
			if (acc < 0)
				acc = 0;
			return acc[CHAN_W-1:0];
		endfunction

		function void note_pixel(logic [31:0] argb, bit sof);
			int unsigned w, h;
			logic [RGB_W-1:0] above, two_above;
			res_t want;
			w = (width_reg < MIN_DIM) ? MIN_DIM : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
			h = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
			if (sof) begin
				col = 0;
				row = 0;
			end
			if (col >= w) begin
				col = 0;
				row++;
			end
			if (row >= h)
				row = 0;
			above = line_above[col];
			two_above = line_two_above[col];
			line_two_above[col] = above;
			line_above[col] = argb[RGB_W-1:0];
			window[0] = window[1];
			window[1] = window[2];
			window[2] = two_above;
			window[3] = window[4];
			window[4] = window[5];
			window[5] = above;
			window[6] = window[7];
			window[7] = window[8];
			window[8] = argb[RGB_W-1:0];
			if (row >= 2 && col >= 2) begin
				want.out_argb = {ALPHA_OPAQUE, weigh_channel(16), weigh_channel(8), weigh_channel(0)};
				want.out_row = ROW_W'(row - 1);
				want.out_col = OCOL_W'(col - 1);
				want.last_of_frame = (row == h - 1) && (col == w - 1);
				pending_filtered.push_back(want);
			end
			col++;
			if (col >= w) begin
				col = 0;
				row++;
				if (row >= h)
					row = 0;
			end
		endfunction

		function void report(string field, logic [31:0] want_v, logic [31:0] got_v);
			mismatches++;
			if (mismatches <= ERR_SHOW)
				$error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
		endfunction

		function void check_filtered(res_t got);
			res_t want;
			results_seen++;
			if (pending_filtered.size() == 0) begin
				report("unexpected result out_argb", '0, got.out_argb);
				return;
			end
			want = pending_filtered.pop_front();
			if (got.out_argb !== want.out_argb)
				report("out_argb", want.out_argb, got.out_argb);
			if (got.out_row !== want.out_row)
				report("out_row", want.out_row, got.out_row);
			if (got.out_col !== want.out_col)
				report("out_col", want.out_col, got.out_col);
			if (got.last_of_frame !== want.last_of_frame)
				report("last_of_frame", want.last_of_frame, got.last_of_frame);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [CFG_W-1:0]      cfg_wdata;
	filtered_pixel_board   sb;
	bit                    quiet;
	int                    hold_left;
	int                    pixels_sent;
	int                    settings_used;

	rgbc_stream_if #(.T(pix_req_t)) pix_if ();
	rgbc_stream_if #(.T(res_t))     res_if ();

	rgb_conv3x3_clamp u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix_in    (pix_if),
		.res_out   (res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic logic [31:0] random_pixel();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return {8'($urandom_range(0, 255)), {8{$urandom_range(0, 1) == 1}},
				{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}}};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pack_taps(int taps [NUM_TAPS]);
		logic [CFG_W-1:0] kv;
		for (int k = 0; k < NUM_TAPS; k++)
			kv[COEF_W*k +: COEF_W] = taps[k][COEF_W-1:0];
		return kv;
	endfunction

	function automatic logic [CFG_W-1:0] random_kernel();
		int taps [NUM_TAPS];
		case ($urandom_range(0, 6))
			0: return CFG_W'({$urandom, $urandom});
			1: taps = '{0, 0, 0, 0, 1, 0, 0, 0, 0};
			2: taps = '{default: 1};
			3: taps = '{default: 63};
			4: taps = '{default: -64};
			5: taps = '{0, -1, 0, -1, 5, -1, 0, -1, 0};
			default: foreach (taps[i]) taps[i] = int'($urandom_range(0, 8)) - 4;
		endcase
		return pack_taps(taps);
	endfunction

	// Check results and stall the output side.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_filtered(res_if.data);
		if (hold_left > 0) begin
			res_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			res_if.ready <= 1'b1;
			hold_left <= pick_gap();
		end
	end

	task automatic send_pixel(logic [31:0] argb, bit sof);
		pix_req_t req;
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.pixel_argb = argb;
		req.start_of_frame = sof;
		pix_if.data <= req;
		pix_if.valid <= 1'b1;
		do @(posedge clk); while (!pix_if.ready);
		sb.note_pixel(argb, sof);
		pixels_sent++;
	endtask

	task automatic send_frame(int npix, bit marked);
		for (int i = 0; i < npix; i++)
			send_pixel(random_pixel(), marked && i == 0);
	endtask

	task automatic drain_pending();
		pix_if.valid <= 1'b0;
		while (sb.pending_filtered.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(logic [CFG_W-1:0] taps, bit blur, int wv, int hv);
		drain_pending();
		cfg_we <= 1'b1;
		cfg_index <= CFG_KERNEL_COEFS;
		cfg_wdata <= taps;
		@(posedge clk);
		cfg_index <= CFG_DIVIDE_BY_NINE;
		cfg_wdata <= CFG_W'(blur);
		@(posedge clk);
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_wdata <= CFG_W'(wv);
		@(posedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_wdata <= CFG_W'(hv);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(CFG_KERNEL_COEFS, taps);
		sb.set_reg(CFG_DIVIDE_BY_NINE, CFG_W'(blur));
		sb.set_reg(CFG_IMAGE_WIDTH, CFG_W'(wv));
		sb.set_reg(CFG_IMAGE_HEIGHT, CFG_W'(hv));
		settings_used++;
	endtask

	initial begin
		#(LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [31:0] probe_px [NUM_TAPS];
		int taps [NUM_TAPS];
		int wv, hv, w_eff, h_eff, kind, nframes, first_random, r;
		bit whole;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_KERNEL_COEFS;
		cfg_wdata = '0;
		pix_if.valid = 1'b0;
		pix_if.data = '0;
		res_if.ready = 1'b0;
		quiet = 1'b0;
		hold_left = 0;
		pixels_sent = 0;
		settings_used = 0;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		probe_px = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_0000, 32'h0000_FF00, 32'hFF12_3456,
			32'h0000_00FF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8080_8080};
		taps = '{0, 0, 0, 0, 1, 0, 0, 0, 0};
		apply_setting(pack_taps(taps), 1'b0, 3, 3);
		foreach (probe_px[i])
			send_pixel(probe_px[i], i == 0);
		// Box blur, widths below range, a frame cut short by a new start mark.
		taps = '{default: 1};
		apply_setting(pack_taps(taps), 1'b1, 0, 0);
		for (int i = 0; i < 4; i++)
			send_pixel(random_pixel(), i == 0);
		foreach (probe_px[i])
			send_pixel(probe_px[NUM_TAPS - 1 - i], i == 0);

		first_random = pixels_sent;
		while (pixels_sent - first_random < RANDOM_ITEMS) begin
			r = $urandom_range(0, 19);
			wv = (r < 3) ? $urandom_range(0, 2) : ((r < 6) ? $urandom_range(13, 40)
				: $urandom_range(3, 12));
			r = $urandom_range(0, 19);
			hv = (r < 3) ? $urandom_range(0, 2) : ((r < 5) ? $urandom_range(7, 12)
				: $urandom_range(3, 6));
			apply_setting(random_kernel(), $urandom_range(0, 1) == 1, wv, hv);
			w_eff = (wv < MIN_DIM) ? MIN_DIM : wv;
			h_eff = (hv < MIN_DIM) ? MIN_DIM : hv;
			quiet = ($urandom_range(0, 3) == 0);
			nframes = $urandom_range(1, 4);
			whole = 1'b0;
			for (int f = 0; f < nframes && pixels_sent - first_random < RANDOM_ITEMS; f++) begin
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					send_frame(w_eff * h_eff, !whole || $urandom_range(0, 1) == 1);
					whole = 1'b1;
				end else if (kind < 9) begin
					send_frame($urandom_range(1, w_eff * h_eff - 1), 1'b1);
					whole = 1'b0;
				end else begin
					repeat ($urandom_range(1, 6))
						send_pixel(random_pixel(), $urandom_range(0, 3) == 0);
					whole = 1'b0;
				end
			end
		end

		drain_pending();
		$display("Sent %0d pixels under %0d register settings, checked %0d filtered results",
			pixels_sent, settings_used, sb.results_seen);
		$display("Frames from 3x3 up to 40x12, blur on and off, whole, cut short and unmarked");
		if (sb.mismatches == 0 && sb.pending_filtered.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
